/* rtl/pgmh_pkg.sv */
package pgmh_pkg;

   localparam int COUNT_W = 16;
   localparam int HTOT_W  = 40;
   localparam int CTOT_W  = 32;
   localparam int H_W     = 24;
   localparam int CH_W    = 16;
   localparam int CSR_W   = 23;

   localparam logic [1:0] CSR_GRID_WIDTH = 2'd0;
   localparam logic [1:0] CSR_GRID_DEPTH = 2'd1;
   localparam logic [1:0] CSR_HEIGHT_TOP = 2'd2;

   localparam logic [1:0] ST_MEASURED = 2'd0;
   localparam logic [1:0] ST_FILLED   = 2'd1;
   localparam logic [1:0] ST_EDGE     = 2'd2;
   localparam logic [1:0] ST_OUTSIDE  = 2'd3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
   localparam logic [CH_W-1:0]    CH_WHITE  = 16'hFFFF;

   localparam logic [1:0] DIV_HEIGHT = 2'd0;
   localparam logic [1:0] DIV_RED    = 2'd1;
   localparam logic [1:0] DIV_GREEN  = 2'd2;
   localparam logic [1:0] DIV_BLUE   = 2'd3;

   typedef struct packed {
      logic [COUNT_W-1:0]       count;
      logic signed [HTOT_W-1:0] htot;
      logic [CTOT_W-1:0]        rtot;
      logic [CTOT_W-1:0]        gtot;
      logic [CTOT_W-1:0]        btot;
   } entry_type;

   typedef struct packed {
      logic start;
      logic wide;
   } div_req_type;

   // Neighbor offsets plus one, in scan order row by row.
   function automatic logic [1:0] nb_dx(input logic [2:0] n);
      logic [1:0] r;
      case (n)
         3'd0, 3'd3, 3'd5: r = 2'd0;
         3'd1, 3'd6:       r = 2'd1;
         default:          r = 2'd2;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] nb_dz(input logic [2:0] n);
      logic [1:0] r;
      case (n)
         3'd0, 3'd1, 3'd2: r = 2'd0;
         3'd3, 3'd4:       r = 2'd1;
         default:          r = 2'd2;
      endcase
      return r;
   endfunction

endpackage

/* rtl/pgmh_div.sv */
module pgmh_div (
   input  logic                      clock,
   input  logic                      reset,
   input  pgmh_pkg::div_req_type     req,
   input  logic [39:0]               num,
   input  logic [15:0]               den,
   output logic                      done,
   output logic [23:0]               quo
);

   // Quotient is known to fit in 24 bits (wide) or 16 bits, so the top of
   // the numerator is already below the divisor.
   logic [15:0] rem_ff, rem_in;
   logic [23:0] num_ff, num_in;
   logic [23:0] quo_ff, quo_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [16:0] trial;
   logic [16:0] diff;

   assign trial = {rem_ff, num_ff[23]};
   assign diff  = trial - {1'b0, den};

   always_comb begin
      rem_in  = rem_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (req.start) begin
         run_in = 1'b1;
         quo_in = '0;
         if (req.wide) begin
            rem_in = num[39:24];
            num_in = num[23:0];
            cnt_in = 5'd24;
         end else begin
            rem_in = num[31:16];
            num_in = {num[15:0], 8'd0};
            cnt_in = 5'd16;
         end
      end else if (run_ff) begin
         num_in = {num_ff[22:0], 1'b0};
         if (!diff[16]) begin
            rem_in = diff[15:0];
            quo_in = {quo_ff[22:0], 1'b1};
         end else begin
            rem_in = trial[15:0];
            quo_in = {quo_ff[22:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

/* rtl/point_grid_mean_height_binning_core.sv */
// Mean-height binning grid for point-cloud samples.
// Input transactions are taken on req_* at a rising edge where start is high
// and busy is low. With req_mode low a point inside the grid is added to its
// cell (count, height sum and color sums, all saturating at a full count);
// it makes no result. With req_mode high one cell is read and exactly one
// result appears on rsp_* with rsp_valid high for a single cycle; the receiver
// cannot stall, so it must take the result in that cycle.
// All cell totals live in one synchronous memory, one entry per cell. An
// accumulate is a read-modify-write that keeps busy high through the read
// (S_RD) and the write-back (S_DAT), so the next point is taken only after
// the write. A read of a measured cell runs four divisions on the shared
// serial divider (24 steps for the height, 16 for each color) and shows its
// result once they are done; the next transaction can be taken while that
// result is on rsp_*. An empty interior cell visits its eight neighbors the
// same way. Reads outside the grid answer in the cycle after they are taken,
// reads of empty edge cells from S_USE after the read in S_RD and S_DAT.
// After reset the memory is swept to zero, one entry per cycle, over all
// MAX_GRID_WIDTH * MAX_GRID_DEPTH entries (4096 at the defaults); busy stays
// high during the sweep. The csr_* port is a plain write port; it is meant to
// be written only while no transaction is in flight.
module point_grid_mean_height_binning_core #(
   parameter int MAX_GRID_WIDTH = 64,
   parameter int MAX_GRID_DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_mode,
   input  logic signed [15:0] req_cell_x,
   input  logic signed [15:0] req_cell_z,
   input  logic signed [23:0] req_point_height,
   input  logic [15:0]        req_point_red,
   input  logic [15:0]        req_point_green,
   input  logic [15:0]        req_point_blue,
   output logic               rsp_valid,
   output logic signed [23:0] rsp_cell_height,
   output logic [15:0]        rsp_cell_red,
   output logic [15:0]        rsp_cell_green,
   output logic [15:0]        rsp_cell_blue,
   output logic [1:0]         rsp_cell_status,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [22:0]        csr_wdata
);

   localparam int DEPTH = MAX_GRID_WIDTH * MAX_GRID_DEPTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int XW    = $clog2(MAX_GRID_WIDTH);
   localparam int ZW    = $clog2(MAX_GRID_DEPTH);
   localparam logic [15:0] MAXW16 = 16'(MAX_GRID_WIDTH);
   localparam logic [15:0] MAXD16 = 16'(MAX_GRID_DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_CLEAR = 7'b0000010,
      S_RD    = 7'b0000100,
      S_DAT   = 7'b0001000,
      S_DIV   = 7'b0010000,
      S_USE   = 7'b0100000,
      S_FIN   = 7'b1000000
   } state_type;

   // Configuration registers.
   logic [6:0]  grid_width_ff, grid_depth_ff;
   logic [22:0] height_top_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff <= 7'd64;
         grid_depth_ff <= 7'd64;
         height_top_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            pgmh_pkg::CSR_GRID_WIDTH: grid_width_ff <= csr_wdata[6:0];
            pgmh_pkg::CSR_GRID_DEPTH: grid_depth_ff <= csr_wdata[6:0];
            pgmh_pkg::CSR_HEIGHT_TOP: height_top_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Dimensions in use, clamped to 1..MAX.
   logic [15:0] w_eff, d_eff;

   always_comb begin
      if (grid_width_ff == 7'd0) begin
         w_eff = 16'd1;
      end else if ({9'd0, grid_width_ff} > MAXW16) begin
         w_eff = MAXW16;
      end else begin
         w_eff = {9'd0, grid_width_ff};
      end
      if (grid_depth_ff == 7'd0) begin
         d_eff = 16'd1;
      end else if ({9'd0, grid_depth_ff} > MAXD16) begin
         d_eff = MAXD16;
      end else begin
         d_eff = {9'd0, grid_depth_ff};
      end
   end

   // Cell store.
   pgmh_pkg::entry_type mem [DEPTH];
   pgmh_pkg::entry_type mem_q;
   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   pgmh_pkg::entry_type wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_q <= mem[rd_addr];
      end
   end

   // Control and working registers.
   state_type           state_ff, state_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic                mode_ff, mode_in;
   logic [XW-1:0]       x_ff, x_in;
   logic [ZW-1:0]       z_ff, z_in;
   logic signed [23:0]  ph_ff, ph_in;
   logic [15:0]         pr_ff, pr_in, pg_ff, pg_in, pb_ff, pb_in;
   logic                center_ff, center_in;
   logic [2:0]          nb_ff, nb_in;
   logic [1:0]          dph_ff, dph_in;
   logic [23:0]         qh_ff, qh_in;
   logic [15:0]         qr_ff, qr_in, qg_ff, qg_in, qb_ff, qb_in;
   logic signed [26:0]  hs_ff, hs_in;
   logic [18:0]         rs_ff, rs_in, gs_ff, gs_in, bs_ff, bs_in;
   logic                rv_ff, rv_in;
   logic signed [23:0]  rh_ff, rh_in;
   logic [15:0]         rr_ff, rr_in, rg_ff, rg_in, rb_ff, rb_in;
   logic [1:0]          rst_ff, rst_in;

   // Divider hookup.
   pgmh_pkg::div_req_type div_req;
   logic [1:0]            div_sel;
   logic [39:0]           div_num;
   logic                  div_done;
   logic [23:0]           div_quo;
   logic [39:0]           hmag;
   logic [15:0]           half_cnt;

   assign half_cnt = {1'b0, mem_q.count[15:1]};
   assign hmag     = mem_q.htot[39] ? 40'(-mem_q.htot) : 40'(mem_q.htot);

   always_comb begin
      case (div_sel)
         pgmh_pkg::DIV_HEIGHT: div_num = hmag + {24'd0, half_cnt};
         pgmh_pkg::DIV_RED:    div_num = {8'd0, mem_q.rtot} + {24'd0, half_cnt};
         pgmh_pkg::DIV_GREEN:  div_num = {8'd0, mem_q.gtot} + {24'd0, half_cnt};
         default:              div_num = {8'd0, mem_q.btot} + {24'd0, half_cnt};
      endcase
   end

   pgmh_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .num   (div_num),
      .den   (mem_q.count),
      .done  (div_done),
      .quo   (div_quo)
   );

   // Value of the cell just read: its mean (height less height_top), or -height_top and white if empty.
   logic               cur_measured;
   logic signed [23:0] cur_h;
   logic [15:0]        cur_r, cur_g, cur_b;
   logic signed [25:0] mean_h, diff_h;

   always_comb begin
      mean_h = mem_q.htot[39] ? -$signed({2'b00, qh_ff}) : $signed({2'b00, qh_ff});
      diff_h = mean_h - $signed({3'b000, height_top_ff});
      cur_measured = (mem_q.count != '0);
      if (!cur_measured) begin
         cur_h = -$signed({1'b0, height_top_ff});
         cur_r = pgmh_pkg::CH_WHITE;
         cur_g = pgmh_pkg::CH_WHITE;
         cur_b = pgmh_pkg::CH_WHITE;
      end else begin
         if (diff_h > 26'sd8388607) begin
            cur_h = 24'sh7FFFFF;
         end else if (diff_h < -26'sd8388608) begin
            cur_h = 24'sh800000;
         end else begin
            cur_h = diff_h[23:0];
         end
         cur_r = qr_ff;
         cur_g = qg_ff;
         cur_b = qb_ff;
      end
   end

   // Neighbor average, rounded half away from zero for height.
   logic [26:0]        hs_mag;
   logic [23:0]        hs_q;
   logic signed [24:0] fill_h;
   logic signed [23:0] fill_hs;

   always_comb begin
      hs_mag = hs_ff[26] ? 27'(-hs_ff) : 27'(hs_ff);
      hs_q   = 24'((hs_mag + 27'd4) >> 3);
      fill_h = hs_ff[26] ? -$signed({1'b0, hs_q}) : $signed({1'b0, hs_q});
      if (fill_h > 25'sd8388607) begin
         fill_hs = 24'sh7FFFFF;
      end else if (fill_h < -25'sd8388608) begin
         fill_hs = 24'sh800000;
      end else begin
         fill_hs = fill_h[23:0];
      end
   end

   // Addresses and region tests.
   logic          req_inside;
   logic [AW-1:0] center_addr, nb_addr;
   logic [31:0]   nx, nz;
   logic          interior;

   assign req_inside = !req_cell_x[15] && !req_cell_z[15]
                       && ($unsigned(req_cell_x) < w_eff)
                       && ($unsigned(req_cell_z) < d_eff);
   assign center_addr = AW'(32'(z_ff) * 32'(MAX_GRID_WIDTH) + 32'(x_ff));
   assign nx = 32'(x_ff) + 32'(pgmh_pkg::nb_dx(nb_ff)) - 32'd1;
   assign nz = 32'(z_ff) + 32'(pgmh_pkg::nb_dz(nb_ff)) - 32'd1;
   assign nb_addr = AW'(nz * 32'(MAX_GRID_WIDTH) + nx);
   assign interior = (x_ff != '0) && (z_ff != '0)
                     && (16'(x_ff) + 16'd1 < w_eff)
                     && (16'(z_ff) + 16'd1 < d_eff);

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      mode_in   = mode_ff;
      x_in      = x_ff;
      z_in      = z_ff;
      ph_in     = ph_ff;
      pr_in     = pr_ff;
      pg_in     = pg_ff;
      pb_in     = pb_ff;
      center_in = center_ff;
      nb_in     = nb_ff;
      dph_in    = dph_ff;
      qh_in     = qh_ff;
      qr_in     = qr_ff;
      qg_in     = qg_ff;
      qb_in     = qb_ff;
      hs_in     = hs_ff;
      rs_in     = rs_ff;
      gs_in     = gs_ff;
      bs_in     = bs_ff;
      rv_in     = 1'b0;
      rh_in     = rh_ff;
      rr_in     = rr_ff;
      rg_in     = rg_ff;
      rb_in     = rb_ff;
      rst_in    = rst_ff;
      rd_en     = 1'b0;
      rd_addr   = center_ff ? center_addr : nb_addr;
      wr_en     = 1'b0;
      wr_addr   = center_addr;
      wr_data   = mem_q;
      div_req   = '0;
      div_sel   = dph_ff;

      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               mode_in   = req_mode;
               x_in      = req_cell_x[XW-1:0];
               z_in      = req_cell_z[ZW-1:0];
               ph_in     = req_point_height;
               pr_in     = req_point_red;
               pg_in     = req_point_green;
               pb_in     = req_point_blue;
               center_in = 1'b1;
               if (req_inside) begin
                  state_in = S_RD;
               end else if (req_mode) begin
                  rv_in  = 1'b1;
                  rh_in  = '0;
                  rr_in  = '0;
                  rg_in  = '0;
                  rb_in  = '0;
                  rst_in = pgmh_pkg::ST_OUTSIDE;
               end
            end
         end
         S_RD: begin
            rd_en    = 1'b1;
            state_in = S_DAT;
         end
         S_DAT: begin
            if (!mode_ff) begin
               // Accumulate; a full cell drops the point whole.
               if (mem_q.count != pgmh_pkg::COUNT_MAX) begin
                  wr_en        = 1'b1;
                  wr_data.count = mem_q.count + 16'd1;
                  wr_data.htot = mem_q.htot + 40'(ph_ff);
                  wr_data.rtot = mem_q.rtot + {16'd0, pr_ff};
                  wr_data.gtot = mem_q.gtot + {16'd0, pg_ff};
                  wr_data.btot = mem_q.btot + {16'd0, pb_ff};
               end
               state_in = S_IDLE;
            end else if (mem_q.count == '0) begin
               state_in = S_USE;
            end else begin
               div_req.start = 1'b1;
               div_req.wide  = 1'b1;
               div_sel       = pgmh_pkg::DIV_HEIGHT;
               dph_in        = pgmh_pkg::DIV_HEIGHT;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               case (dph_ff)
                  pgmh_pkg::DIV_HEIGHT: qh_in = div_quo;
                  pgmh_pkg::DIV_RED:    qr_in = div_quo[15:0];
                  pgmh_pkg::DIV_GREEN:  qg_in = div_quo[15:0];
                  default:              qb_in = div_quo[15:0];
               endcase
               if (dph_ff == pgmh_pkg::DIV_BLUE) begin
                  state_in = S_USE;
               end else begin
                  div_req.start = 1'b1;
                  div_req.wide  = 1'b0;
                  div_sel       = dph_ff + 2'd1;
                  dph_in        = dph_ff + 2'd1;
               end
            end
         end
         S_USE: begin
            if (center_ff) begin
               if (cur_measured || !interior) begin
                  rv_in    = 1'b1;
                  rh_in    = cur_h;
                  rr_in    = cur_r;
                  rg_in    = cur_g;
                  rb_in    = cur_b;
                  rst_in   = cur_measured ? pgmh_pkg::ST_MEASURED : pgmh_pkg::ST_EDGE;
                  state_in = S_IDLE;
               end else begin
                  center_in = 1'b0;
                  nb_in     = '0;
                  hs_in     = '0;
                  rs_in     = '0;
                  gs_in     = '0;
                  bs_in     = '0;
                  state_in  = S_RD;
               end
            end else begin
               hs_in = hs_ff + 27'(cur_h);
               rs_in = rs_ff + 19'(cur_r);
               gs_in = gs_ff + 19'(cur_g);
               bs_in = bs_ff + 19'(cur_b);
               if (nb_ff == 3'd7) begin
                  state_in = S_FIN;
               end else begin
                  nb_in    = nb_ff + 3'd1;
                  state_in = S_RD;
               end
            end
         end
         S_FIN: begin
            rv_in    = 1'b1;
            rh_in    = fill_hs;
            rr_in    = 16'((rs_ff + 19'd4) >> 3);
            rg_in    = 16'((gs_ff + 19'd4) >> 3);
            rb_in    = 16'((bs_ff + 19'd4) >> 3);
            rst_in   = pgmh_pkg::ST_FILLED;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         rv_ff     <= 1'b0;
         center_ff <= 1'b1;
         nb_ff     <= '0;
         dph_ff    <= '0;
         mode_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         rv_ff     <= rv_in;
         center_ff <= center_in;
         nb_ff     <= nb_in;
         dph_ff    <= dph_in;
         mode_ff   <= mode_in;
      end
      x_ff   <= x_in;
      z_ff   <= z_in;
      ph_ff  <= ph_in;
      pr_ff  <= pr_in;
      pg_ff  <= pg_in;
      pb_ff  <= pb_in;
      qh_ff  <= qh_in;
      qr_ff  <= qr_in;
      qg_ff  <= qg_in;
      qb_ff  <= qb_in;
      hs_ff  <= hs_in;
      rs_ff  <= rs_in;
      gs_ff  <= gs_in;
      bs_ff  <= bs_in;
      rh_ff  <= rh_in;
      rr_ff  <= rr_in;
      rg_ff  <= rg_in;
      rb_ff  <= rb_in;
      rst_ff <= rst_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rv_ff;
   assign rsp_cell_height = rh_ff;
   assign rsp_cell_red    = rr_ff;
   assign rsp_cell_green  = rg_ff;
   assign rsp_cell_blue   = rb_ff;
   assign rsp_cell_status = rst_ff;

endmodule
